@@ rtl/rsc_pkg.sv @@
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int CHAR_W    = 8;
    localparam int KW_WIN_W  = 56;
    localparam int HINT_WIN_W = 64;

    // Packed keyword text, first character in the highest byte
    localparam logic [47:0] KW_SELECT   = "SELECT";
    localparam logic [47:0] KW_INSERT   = "INSERT";
    localparam logic [47:0] KW_UPDATE   = "UPDATE";
    localparam logic [47:0] KW_DELETE   = "DELETE";
    localparam logic [39:0] KW_ALTER    = "ALTER";
    localparam logic [47:0] KW_CREATE   = "CREATE";
    localparam logic [31:0] KW_DROP     = "DROP";
    localparam logic [39:0] KW_MERGE    = "MERGE";
    localparam logic [63:0] KW_TRUNCATE = "TRUNCATE";
    localparam logic [31:0] KW_COPY     = "COPY";
    localparam logic [39:0] KW_BEGIN    = "BEGIN";
    localparam logic [47:0] KW_COMMIT   = "COMMIT";
    localparam logic [63:0] KW_ROLLBACK = "ROLLBACK";
    localparam logic [55:0] KW_CLUSTER  = "CLUSTER";

    localparam logic [15:0] HINT_OPEN_HEAD = "/*";
    localparam logic [7:0]  CH_PLUS   = "+";
    localparam logic [7:0]  CH_STAR   = "*";
    localparam logic [7:0]  CH_SLASH  = "/";
    localparam logic [7:0]  CH_Y      = "Y";
    localparam logic [7:0]  CH_SQUOTE = 8'h27;
    localparam logic [7:0]  CH_DQUOTE = 8'h22;
    localparam logic [63:0] HINT_RO_HEAD = "READ-ONL";

    typedef enum logic [1:0] {
        MODE_SEARCH  = 2'd0,
        MODE_IN_HINT = 2'd1,
        MODE_STOPPED = 2'd2,
        MODE_MATCHED = 2'd3
    } hint_mode_t;

    typedef struct packed {
        logic              valid;
        logic              live;   // byte is part of the text (before any zero byte)
        logic              last;
        logic [CHAR_W-1:0] ch;     // upper-cased
    } rsc_item_t;

    typedef struct packed {
        logic step;
        logic clear;
    } rsc_scan_ctl_t;

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
            r = c - 8'h20;
        return r;
    endfunction

endpackage

@@ rtl/rsc_in_stage.sv @@
`timescale 1ns / 1ps

module rsc_in_stage
    import rsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
    input  logic              s_axis_tlast,
    input  logic              advance,
    output rsc_item_t         item
);

    logic      valid_reg, valid_next;
    logic      ended_reg, ended_next;
    logic      live_reg;
    logic      last_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic      accept;

    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    // Text end is tracked at accept time; requests stay in order so this matches
    always_comb
    begin
        ended_next = ended_reg;
        if (accept)
        begin
            if (s_axis_tlast)
                ended_next = 1'b0;
            else if (s_axis_tdata == '0)
                ended_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ended_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ended_reg <= ended_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            live_reg <= !ended_reg && (s_axis_tdata != '0);
            last_reg <= s_axis_tlast;
            ch_reg   <= to_upper(s_axis_tdata);
        end
    end

    assign item.valid = valid_reg;
    assign item.live  = live_reg;
    assign item.last  = last_reg;
    assign item.ch    = ch_reg;

endmodule

@@ rtl/rsc_kw_scan.sv @@
`timescale 1ns / 1ps

module rsc_kw_scan
    import rsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rsc_scan_ctl_t     ctl,
    input  logic [CHAR_W-1:0] ch,
    output logic              select_next,
    output logic              write_next
);

    logic [KW_WIN_W-1:0] window_reg, window_next;
    logic                select_reg, write_reg;
    logic [63:0]         win;
    logic                sel_hit, wr_hit;

    assign win = {window_reg, ch};

    assign sel_hit = (win[47:0] == KW_SELECT);
    assign wr_hit  = (win[47:0] == KW_INSERT)   || (win[47:0] == KW_UPDATE) ||
                     (win[47:0] == KW_DELETE)   || (win[39:0] == KW_ALTER)  ||
                     (win[47:0] == KW_CREATE)   || (win[31:0] == KW_DROP)   ||
                     (win[39:0] == KW_MERGE)    || (win == KW_TRUNCATE)     ||
                     (win[31:0] == KW_COPY)     || (win[39:0] == KW_BEGIN)  ||
                     (win[47:0] == KW_COMMIT)   || (win == KW_ROLLBACK)     ||
                     (win[55:0] == KW_CLUSTER);

    always_comb
    begin
        window_next = window_reg;
        select_next = select_reg;
        write_next  = write_reg;
        if (ctl.step)
        begin
            window_next = win[KW_WIN_W-1:0];
            select_next = select_reg || sel_hit;
            write_next  = write_reg || wr_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            select_reg <= 1'b0;
            write_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            window_reg <= '0;
            select_reg <= 1'b0;
            write_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            select_reg <= select_next;
            write_reg  <= write_next;
        end
    end

    a_clear_flags: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctl.clear) |-> (!select_reg && !write_reg && window_reg == '0))
        else $error("keyword flags not cleared after verdict");

    a_sticky_select: assert property (@(posedge clk) disable iff (!rst_n)
        (select_reg && !ctl.clear) |=> select_reg)
        else $error("select flag dropped inside a statement");

endmodule

@@ rtl/rsc_hint_scan.sv @@
`timescale 1ns / 1ps

module rsc_hint_scan
    import rsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rsc_scan_ctl_t     ctl,
    input  logic [CHAR_W-1:0] ch,
    output logic              matched_next
);

    hint_mode_t            mode_reg, mode_next;
    logic [HINT_WIN_W-1:0] window_reg, window_next;
    logic                  sq_odd_reg, sq_odd_next;
    logic                  dq_odd_reg, dq_odd_next;
    logic                  ro_reg, ro_next;
    logic                  sq_tgl, dq_tgl;
    logic                  open_hit, close_hit, ro_hit;

    // Unfilled window bytes are zero and no pattern holds a zero byte,
    // so the fill level never needs checking.
    assign sq_tgl    = (ch == CH_SQUOTE);
    assign dq_tgl    = (ch == CH_DQUOTE);
    assign open_hit  = (ch == CH_PLUS) && (window_reg[15:0] == HINT_OPEN_HEAD);
    assign close_hit = (ch == CH_SLASH) && (window_reg[7:0] == CH_STAR);
    assign ro_hit    = (ch == CH_Y) && (window_reg == HINT_RO_HEAD);

    always_comb
    begin
        mode_next = mode_reg;
        if (ctl.step)
        begin
            case (mode_reg)
                MODE_SEARCH:
                begin
                    if (open_hit)
                        mode_next = ((sq_odd_reg ^ sq_tgl) || (dq_odd_reg ^ dq_tgl))
                                    ? MODE_STOPPED : MODE_IN_HINT;
                end
                MODE_IN_HINT:
                begin
                    if (close_hit)
                        mode_next = ro_reg ? MODE_MATCHED : MODE_SEARCH;
                end
                default:
                    mode_next = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        window_next = window_reg;
        sq_odd_next = sq_odd_reg;
        dq_odd_next = dq_odd_reg;
        ro_next     = ro_reg;
        if (ctl.step)
        begin
            case (mode_reg)
                MODE_SEARCH:
                begin
                    sq_odd_next = sq_odd_reg ^ sq_tgl;
                    dq_odd_next = dq_odd_reg ^ dq_tgl;
                    if (open_hit)
                    begin
                        if (!(sq_odd_next || dq_odd_next))
                        begin
                            ro_next     = 1'b0;
                            window_next = '0;
                        end
                    end
                    else
                        window_next = {window_reg[HINT_WIN_W-CHAR_W-1:0], ch};
                end
                MODE_IN_HINT:
                begin
                    if (close_hit)
                    begin
                        if (!ro_reg)
                        begin
                            sq_odd_next = 1'b0;
                            dq_odd_next = 1'b0;
                            window_next = '0;
                        end
                    end
                    else
                    begin
                        if (ro_hit)
                            ro_next = 1'b1;
                        window_next = {window_reg[HINT_WIN_W-CHAR_W-1:0], ch};
                    end
                end
                default:
                    window_next = window_reg;
            endcase
        end
    end

    assign matched_next = (mode_next == MODE_MATCHED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SEARCH;
            window_reg <= '0;
            sq_odd_reg <= 1'b0;
            dq_odd_reg <= 1'b0;
            ro_reg     <= 1'b0;
        end
        else if (ctl.clear)
        begin
            mode_reg   <= MODE_SEARCH;
            window_reg <= '0;
            sq_odd_reg <= 1'b0;
            dq_odd_reg <= 1'b0;
            ro_reg     <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            sq_odd_reg <= sq_odd_next;
            dq_odd_reg <= dq_odd_next;
            ro_reg     <= ro_next;
        end
    end

    a_matched_has_ro: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_MATCHED) |-> ro_reg)
        else $error("matched without READ-ONLY seen");

    a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !ctl.clear && mode_reg == MODE_SEARCH && mode_next == MODE_IN_HINT)
        |=> (window_reg == '0 && !ro_reg))
        else $error("hint body window not cleared on open");

endmodule

@@ rtl/sql_read_only_classifier.sv @@
`timescale 1ns / 1ps

// SQL read-only classifier.
// Input stream: one statement byte per request on s_axis_tdata, s_axis_tlast on
// the final byte. A zero byte ends the text; later bytes up to tlast are ignored.
// Output stream: one verdict request per statement, issued for the tlast byte.
// Bytes with tlast low produce nothing on the output.
// Throughput: one byte per cycle, with no gap between statements, except while a tlast byte waits (see Stall).
// Path: the tlast byte is held in the input register, then its verdict is
// loaded into the result register, which drives m_axis_tvalid.
// Each byte is scanned combinationally from the input register: keyword window
// compare and the hint tracker update.
// Stall: the result register holds its verdict while m_axis_tready is low;
// bytes of the next statement keep flowing, and only a second tlast byte
// waits in the input register until the verdict is taken.
// Reset: all scanner state clears, no request is pending on either side.
// Scanner state also clears after every verdict, so each statement starts fresh.
module sql_read_only_classifier
    import rsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] read_only, [1] hint_matched,
                                       // [2] select_found, [3] write_keyword_found
);

    rsc_item_t     item;
    rsc_scan_ctl_t ctl;
    logic          advance;
    logic          verdict;
    logic          matched_next, select_next, write_next;

    logic out_valid_reg, out_valid_next;
    logic ro_reg, hint_reg, sel_reg, wr_reg;

    // A non-last byte never touches the result register, so it never waits
    assign advance   = item.valid && (!item.last || !out_valid_reg || m_axis_tready);
    assign verdict   = advance && item.last;
    assign ctl.step  = advance && item.live;
    assign ctl.clear = verdict;

    rsc_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item          (item)
    );

    rsc_hint_scan u_hint_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .ch           (item.ch),
        .matched_next (matched_next)
    );

    rsc_kw_scan u_kw_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .ch          (item.ch),
        .select_next (select_next),
        .write_next  (write_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (verdict)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (verdict)
        begin
            ro_reg   <= matched_next || (select_next && !write_next);
            hint_reg <= matched_next;
            sel_reg  <= select_next;
            wr_reg   <= write_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, wr_reg, sel_reg, hint_reg, ro_reg};

    a_hint_implies_ro: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hint_reg) |-> ro_reg)
        else $error("hint verdict without read_only");

    a_keyword_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hint_reg) |-> (ro_reg == (sel_reg && !wr_reg)))
        else $error("keyword verdict inconsistent with flags");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !verdict)
        else $error("pending verdict overwritten");

endmodule
